>>> src/swmf_pkg.sv
// Shared constants and types for the sliding window median filter.
// Depends on nothing; the other files that use it refer to it by scoped names.
package swmf_pkg;

    localparam int WINDOW_DEF      = 20;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int FIELD_BITS      = 32;
    localparam int NUM_CHAN        = 4;

    typedef logic signed [FIELD_BITS-1:0] t_field;

    // Commands from the controller to the datapath, one step of the item sequence each.
    typedef struct packed {
        logic load;
        logic del;
        logic ins;
        logic rd_lo;
        logic rd_hi;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
    } t_dp_status;

endpackage

>>> src/swmf_ifs.sv
// Valid/ready channel interfaces of the median filter: samples in, medians out, config.
// Depends on swmf_pkg for the field type.
interface swmf_in_if;
    logic            valid;
    logic            ready;
    swmf_pkg::t_field sample_x;
    swmf_pkg::t_field sample_y;
    swmf_pkg::t_field sample_z;
    swmf_pkg::t_field sample_yaw;

    modport source (output valid, sample_x, sample_y, sample_z, sample_yaw, input ready);
    modport sink   (input valid, sample_x, sample_y, sample_z, sample_yaw, output ready);
endinterface

interface swmf_out_if;
    logic            valid;
    logic            ready;
    swmf_pkg::t_field median_x;
    swmf_pkg::t_field median_y;
    swmf_pkg::t_field median_z;
    swmf_pkg::t_field median_yaw;

    modport source (output valid, median_x, median_y, median_z, median_yaw, input ready);
    modport sink   (input valid, median_x, median_y, median_z, median_yaw, output ready);
endinterface

interface swmf_cfg_if;
    logic valid;
    logic ready;
    logic enable;

    modport source (output valid, enable, input ready);
    modport sink   (input valid, enable, output ready);
endinterface

>>> src/swmf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependency.
module swmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/swmf_sort_row.sv
// One channel's window kept in ascending order as a row of cells.
// Each cell compares against one key and moves by one place; depends on no package items.
module swmf_sort_row #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_del,
    input  logic                          i_ins,
    input  logic [SAMPLE_BITS-1:0]        i_old_val,
    input  logic [SAMPLE_BITS-1:0]        i_new_val,
    input  logic [$clog2(WINDOW+1)-1:0]   i_valid_cnt,
    input  logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] i_rd_idx,
    output logic [SAMPLE_BITS-1:0]        o_rd_val
);

    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [SAMPLE_BITS-1:0] r_cell [WINDOW];
    logic [SAMPLE_BITS-1:0] w_key;
    logic [WINDOW-1:0]      w_lt;

    assign w_key = i_del ? i_old_val : i_new_val;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            logic [SAMPLE_BITS-1:0] n_cell;

            // Cells past the held count act as larger than any key.
            assign w_lt[gi] = (CNT_W'(gi) < i_valid_cnt) &&
                              ($signed(r_cell[gi]) < $signed(w_key));

            always_comb begin
                n_cell = r_cell[gi];
                if (i_del) begin
                    // The first cell not below the oldest value holds it; close the gap.
                    if (!w_lt[gi]) begin
                        if (gi < WINDOW - 1) begin
                            n_cell = r_cell[(gi < WINDOW - 1) ? gi + 1 : gi];
                        end
                    end
                end else if (i_ins) begin
                    if (!w_lt[gi]) begin
                        if (gi == 0) begin
                            n_cell = w_key;
                        end else if (w_lt[(gi > 0) ? gi - 1 : 0]) begin
                            n_cell = w_key;
                        end else begin
                            n_cell = r_cell[(gi > 0) ? gi - 1 : 0];
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_cell[gi] <= n_cell;
            end
        end
    endgenerate

    assign o_rd_val = r_cell[i_rd_idx];

endmodule

>>> src/swmf_datapath.sv
// Datapath: arrival-order sample store, four sorted rows, middle-value readout and output register.
// Depends on swmf_pkg, swmf_ram and swmf_sort_row.
module swmf_datapath #(
    parameter int WINDOW      = swmf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swmf_pkg::t_dp_cmd    i_cmd,
    output swmf_pkg::t_dp_status o_status,
    input  swmf_pkg::t_field     i_sample_x,
    input  swmf_pkg::t_field     i_sample_y,
    input  swmf_pkg::t_field     i_sample_z,
    input  swmf_pkg::t_field     i_sample_yaw,
    output swmf_pkg::t_field     o_median_x,
    output swmf_pkg::t_field     o_median_y,
    output swmf_pkg::t_field     o_median_z,
    output swmf_pkg::t_field     o_median_yaw
);

    localparam int NCH   = swmf_pkg::NUM_CHAN;
    localparam int FB    = swmf_pkg::FIELD_BITS;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = CNT_W + 1;
    localparam int WIDE  = (SAMPLE_BITS > FB) ? SAMPLE_BITS : FB;

    logic [NCH-1:0][FB-1:0]          w_in;
    logic [NCH-1:0][SAMPLE_BITS-1:0] w_samp;
    logic [NCH-1:0][SAMPLE_BITS-1:0] r_samp;
    logic [NCH-1:0][SAMPLE_BITS-1:0] w_old;
    logic [NCH-1:0][SAMPLE_BITS-1:0] w_rd_val;
    logic [NCH-1:0][SAMPLE_BITS-1:0] r_lo;
    logic [NCH-1:0][SAMPLE_BITS-1:0] r_hi;
    logic [NCH-1:0][FB-1:0]          r_out;

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_oldest;
    logic [SUM_W-1:0] w_slot_sum;
    logic [IDX_W-1:0] w_slot;
    logic [CNT_W-1:0] w_valid_cnt;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_full;

    assign w_in     = {i_sample_yaw, i_sample_z, i_sample_y, i_sample_x};
    assign w_full   = (r_count == CNT_W'(WINDOW));
    assign o_status = '{full: w_full};

    // Next free slot, or the oldest slot once the window is full.
    assign w_slot_sum = SUM_W'(r_oldest) + SUM_W'(r_count);
    always_comb begin
        if (w_full) begin
            w_slot = r_oldest;
        end else if (w_slot_sum >= SUM_W'(WINDOW)) begin
            w_slot = IDX_W'(w_slot_sum - SUM_W'(WINDOW));
        end else begin
            w_slot = IDX_W'(w_slot_sum);
        end
    end

    // After a delete the row holds one fewer sample than the count shows.
    assign w_valid_cnt = (i_cmd.ins && w_full) ? CNT_W'(WINDOW - 1) : r_count;
    assign w_rd_idx    = i_cmd.rd_hi ? IDX_W'(r_count >> 1)
                                     : IDX_W'((r_count - CNT_W'(1)) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
        end else if (i_cmd.ins) begin
            if (w_full) begin
                r_oldest <= (r_oldest == IDX_W'(WINDOW - 1)) ? '0 : r_oldest + IDX_W'(1);
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    swmf_ram #(
        .WIDTH (NCH * SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (w_slot),
        .i_wdata (w_samp),
        .i_raddr (r_oldest),
        .o_rdata (w_old)
    );

    genvar gc;
    generate
        for (gc = 0; gc < NCH; gc++) begin : g_chan
            logic [WIDE-1:0]        w_in_wide;
            logic [SAMPLE_BITS:0]   w_sum;
            logic [SAMPLE_BITS-1:0] w_med;
            logic [WIDE-1:0]        w_med_wide;

            assign w_in_wide  = WIDE'(w_in[gc]);
            assign w_samp[gc] = w_in_wide[SAMPLE_BITS-1:0];

            // Floor of the mean of the two middle values; both are the same for an odd count.
            assign w_sum      = {r_lo[gc][SAMPLE_BITS-1], r_lo[gc]} +
                                {r_hi[gc][SAMPLE_BITS-1], r_hi[gc]};
            assign w_med      = w_sum[SAMPLE_BITS:1];
            assign w_med_wide = WIDE'(w_med);

            swmf_sort_row #(
                .WINDOW      (WINDOW),
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_row (
                .i_clk       (i_clk),
                .i_del       (i_cmd.del),
                .i_ins       (i_cmd.ins),
                .i_old_val   (w_old[gc]),
                .i_new_val   (r_samp[gc]),
                .i_valid_cnt (w_valid_cnt),
                .i_rd_idx    (w_rd_idx),
                .o_rd_val    (w_rd_val[gc])
            );

            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_samp[gc] <= w_samp[gc];
                end
                if (i_cmd.rd_lo) begin
                    r_lo[gc] <= w_rd_val[gc];
                end
                if (i_cmd.rd_hi) begin
                    r_hi[gc] <= w_rd_val[gc];
                end
                if (i_cmd.out_load) begin
                    r_out[gc] <= w_med_wide[FB-1:0];
                end
            end
        end
    endgenerate

    assign o_median_x   = r_out[0];
    assign o_median_y   = r_out[1];
    assign o_median_z   = r_out[2];
    assign o_median_yaw = r_out[3];

endmodule

>>> src/swmf_ctrl.sv
// Controller: handshakes, enable register and the per-item step sequence.
// Depends on swmf_pkg for the command and status structs.
module swmf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_enable,
    input  swmf_pkg::t_dp_status i_status,
    output swmf_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEL  = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_RLO  = 3'd3;
    localparam logic [2:0] S_RHI  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_enable;
    logic       r_out_valid;
    logic       n_out_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                // With the filter disabled a transfer is taken and dropped.
                if (i_in_valid && r_enable) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEL;
                end
            end
            S_DEL: begin
                o_cmd.del = i_status.full;
                n_state   = S_INS;
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = S_RLO;
            end
            S_RLO: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_RHI;
            end
            S_RHI: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_enable <= i_cfg_enable;
            end
        end
    end

endmodule

>>> src/sliding_window_median_filter.sv
// Four-channel pose median filter over the last WINDOW samples per channel.
// Channels: i_sample (valid/ready, one x/y/z/yaw sample per transfer), o_median
// (valid/ready, one median set per processed sample) and i_cfg (valid/ready,
// writes the enable bit; always ready).
// A sample transfer with enable set produces exactly one result; with enable
// clear the transfer is taken and discarded. While fewer than WINDOW samples
// are held, the median covers the samples held so far; an even count yields
// the floor of the mean of the two middle values.
// o_median.valid rises with the load of the output register. i_sample is ready
// only between items, so a new sample is taken only after the previous one has
// run the step sequence of the sorted rows (load, delete oldest once the window
// is full, insert, two middle reads, sum into the output register).
// Reset (synchronous, active low) empties the window and sets enable to 1.
// If the receiver stalls, the result waits in the output register while the
// next sample may already be taken; that item then holds in its last step
// until the output register frees.
// Depends on swmf_pkg, the channel interfaces, swmf_ctrl and swmf_datapath.
module sliding_window_median_filter #(
    parameter int WINDOW      = swmf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swmf_in_if.sink   i_sample,
    swmf_out_if.source o_median,
    swmf_cfg_if.sink  i_cfg
);

    swmf_pkg::t_dp_cmd    w_cmd;
    swmf_pkg::t_dp_status w_status;

    swmf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_sample.valid),
        .o_in_ready   (i_sample.ready),
        .o_out_valid  (o_median.valid),
        .i_out_ready  (o_median.ready),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_enable (i_cfg.enable),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    swmf_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_sample_x   (i_sample.sample_x),
        .i_sample_y   (i_sample.sample_y),
        .i_sample_z   (i_sample.sample_z),
        .i_sample_yaw (i_sample.sample_yaw),
        .o_median_x   (o_median.median_x),
        .o_median_y   (o_median.median_y),
        .o_median_z   (o_median.median_z),
        .o_median_yaw (o_median.median_yaw)
    );

endmodule

>>> src/swmf_checker.sv
// Port-level checks for the median filter, attached to the top level by bind.
// Depends on swmf_pkg for the field type and on the top level's ports.
module swmf_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_cfg_valid,
    input logic             i_cfg_ready,
    input logic             i_cfg_enable,
    input swmf_pkg::t_field i_median_x,
    input swmf_pkg::t_field i_median_y,
    input swmf_pkg::t_field i_median_z,
    input swmf_pkg::t_field i_median_yaw
);

    logic r_en;
    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && i_in_ready;

    // Shadow of the enable register as seen through the config port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b1;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_en <= i_cfg_enable;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_median_x) && $stable(i_median_y) &&
            $stable(i_median_z) && $stable(i_median_yaw))
        else $error("stalled result changed");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && r_en |=> !i_in_ready && !$rose(i_out_valid))
        else $error("processed sample did not occupy the block");

    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result appeared while an item was still in progress");

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample.valid),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_median.valid),
    .i_out_ready  (o_median.ready),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_cfg_enable (i_cfg.enable),
    .i_median_x   (o_median.median_x),
    .i_median_y   (o_median.median_y),
    .i_median_z   (o_median.median_z),
    .i_median_yaw (o_median.median_yaw)
);
